// ===== src/fnvrh_pkg.sv =====
// Shared types and constants for the FNV-1a 64-bit record hash unit.
package fnvrh_pkg;

  localparam int HASH_W       = 64;
  localparam int BYTE_W       = 8;
  localparam int TDATA_W      = 256;
  localparam int COUNT_W      = 32;
  localparam int RECORD_LSB   = 32;   // pool_id starts here in tdata
  localparam int BEGIN_BYTES  = COUNT_W / BYTE_W;
  localparam int RECORD_BYTES = (TDATA_W - RECORD_LSB) / BYTE_W;
  localparam int SHIFT_W      = (RECORD_BYTES - 1) * BYTE_W;
  localparam int CNT_W        = $clog2(RECORD_BYTES);

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

  typedef enum logic {
    OP_BEGIN  = 1'b0,
    OP_RECORD = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

endpackage

// ===== src/fnvrh_byte_shifter.sv =====
// Byte shift register that feeds the pending bytes of a transaction, low byte first.
module fnvrh_byte_shifter (
  input  logic                          clk_i,
  input  fnvrh_pkg::shift_ctrl_t        ctrl_i,
  input  logic [fnvrh_pkg::SHIFT_W-1:0] load_data_i,
  output logic [fnvrh_pkg::BYTE_W-1:0]  byte_o
);
  import fnvrh_pkg::*;

  logic [SHIFT_W-1:0] sh_q, sh_d;

  always_comb begin
    sh_d = sh_q;
    if (ctrl_i.load) begin
      sh_d = load_data_i;
    end else if (ctrl_i.shift) begin
      sh_d = {{BYTE_W{1'b0}}, sh_q[SHIFT_W-1:BYTE_W]};
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign byte_o = sh_q[BYTE_W-1:0];

endmodule

// ===== src/fnvrh_mix_step.sv =====
// One FNV-1a byte step: xor the byte in, multiply by the 64-bit FNV prime.
module fnvrh_mix_step (
  input  logic [fnvrh_pkg::HASH_W-1:0] hash_i,
  input  logic [fnvrh_pkg::BYTE_W-1:0] byte_i,
  output logic [fnvrh_pkg::HASH_W-1:0] hash_o
);
  import fnvrh_pkg::*;

  logic [HASH_W-1:0] x;

  assign x = hash_i ^ {{(HASH_W-BYTE_W){1'b0}}, byte_i};

  // prime 0x100000001b3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0, mod 2^64
  assign hash_o = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);

endmodule

// ===== src/fnv1a64_record_hash_unit.sv =====
// Top level of the FNV-1a 64-bit record hash unit, byte-serial datapath.
//
//  channel  | dir | tdata (low bit up)                                   | tuser
//  ---------+-----+------------------------------------------------------+--------
//  s_axis   | in  | num_pools, pool_id, grp_kind, rgn_code,              | opcode
//           |     | block_size_bytes, num_layers, alignment_bytes (256)  |
//  m_axis   | out | running_digest (64)                                  | -
//
// One byte is mixed per cycle through a single xor/constant-multiply step, save
// when the last byte waits for the output. A begin mixes 4 bytes, a record 28;
// the first byte is mixed on accept, the rest come from the byte shift register.
// s_axis_tready is high while no transaction is in flight.
// Reset loads the accumulator with the FNV offset basis and empties the output.
// If the output register is still held when the last byte is due, the last step
// waits until m_axis_tready frees the slot.
module fnv1a64_record_hash_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // num_pools, pool_id, grp_kind, rgn_code,
                                       // block_size_bytes, num_layers, alignment_bytes
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata    // running_digest
);
  import fnvrh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MIX
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;      // bytes still to mix, the current one included
  logic [HASH_W-1:0] acc_q;      // running hash
  logic              m_valid_q;
  logic [HASH_W-1:0] m_data_q;

  logic              accept;
  logic              is_record;
  logic              out_free;
  logic              step;
  logic              last_step;
  logic [HASH_W-1:0] mix_hash_in;
  logic [BYTE_W-1:0] mix_byte_in;
  logic [HASH_W-1:0] mix_hash_out;
  logic [BYTE_W-1:0] sh_byte;
  logic [SHIFT_W-1:0] sh_load;
  shift_ctrl_t       sh_ctrl;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_record     = (s_axis_tuser == OP_RECORD);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign last_step     = (state_q == ST_MIX) && (cnt_q == CNT_W'(1));
  // Hold the final byte while the previous digest still sits in the output.
  assign step          = (state_q == ST_MIX) && (!last_step || out_free);

  // First byte comes straight off the bus; later ones from the shifter.
  always_comb begin
    if (state_q == ST_IDLE) begin
      mix_hash_in = is_record ? acc_q : FNV_BASIS;
      mix_byte_in = is_record ? s_axis_tdata[RECORD_LSB +: BYTE_W]
                              : s_axis_tdata[BYTE_W-1:0];
    end else begin
      mix_hash_in = acc_q;
      mix_byte_in = sh_byte;
    end
  end

  // Remaining bytes: whole record minus its first byte, or the upper count bytes.
  assign sh_load = is_record
                 ? s_axis_tdata[TDATA_W-1:RECORD_LSB+BYTE_W]
                 : {{(SHIFT_W-COUNT_W+BYTE_W){1'b0}}, s_axis_tdata[COUNT_W-1:BYTE_W]};

  assign sh_ctrl.load  = accept;
  assign sh_ctrl.shift = step;

  fnvrh_byte_shifter u_shifter (
    .clk_i       (clk_i),
    .ctrl_i      (sh_ctrl),
    .load_data_i (sh_load),
    .byte_o      (sh_byte)
  );

  fnvrh_mix_step u_mix (
    .hash_i (mix_hash_in),
    .byte_i (mix_byte_in),
    .hash_o (mix_hash_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      acc_q     <= FNV_BASIS;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (accept) begin
        state_q <= ST_MIX;
        acc_q   <= mix_hash_out;
        cnt_q   <= is_record ? CNT_W'(RECORD_BYTES - 1) : CNT_W'(BEGIN_BYTES - 1);
      end else if (step) begin
        acc_q <= mix_hash_out;
        cnt_q <= cnt_q - CNT_W'(1);
        if (last_step) begin
          state_q   <= ST_IDLE;
          m_valid_q <= 1'b1;
          m_data_q  <= mix_hash_out;
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // In flight the byte count stays within a record.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> ((cnt_q != '0) && (cnt_q <= CNT_W'(RECORD_BYTES - 1))))
    else $error("byte count out of range while mixing");

  // A completed last byte step always presents its digest.
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_step && out_free) |=> (m_axis_tvalid && (m_axis_tdata == acc_q)))
    else $error("digest not presented after last byte");

  // An accepted transaction always starts mixing.
  a_accept_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MIX))
    else $error("accepted transaction did not start");

  // The output slot is never overwritten while still held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !(last_step && step))
    else $error("held digest overwritten");
`endif

endmodule

// ===== tb/fnv1a64_record_hash_unit_tb.sv =====
// Self-checking testbench for the FNV-1a 64-bit record hash unit.
`timescale 1ns / 100ps

module fnv1a64_record_hash_unit_tb;
  import fnvrh_pkg::*;

  localparam int          CLK_HALF    = 5;
  localparam int          ITEM_TARGET = 1950;
  localparam int          SETTLE_CYC  = 60;   // margin after the last record
  localparam int          LONG_HOLD   = 400;
  localparam int          MAX_SHOWN   = 10;
  localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;

  // tdata layout, lowest field in the low bits (packed structs list MSB first)
  typedef struct packed {
    logic [31:0] alignment_bytes;
    logic [31:0] num_layers;
    logic [63:0] block_size_bytes;
    logic [31:0] rgn_code;
    logic [31:0] grp_kind;
    logic [31:0] pool_id;
    logic [31:0] num_pools;
  } hash_item_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_e;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata  = '0;   // num_pools, pool_id, grp_kind, rgn_code,
                                      // block_size_bytes, num_layers, alignment_bytes
  logic         s_axis_tuser  = 1'b0; // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;         // running_digest

  // predictor state and expected digests
  logic [63:0]  digest_state = FNV_BASIS;
  logic [63:0]  digest_q[$];
  logic [63:0]  want_digest;

  int           mismatch_cnt = 0;
  int           items_sent   = 0;

  // sender pacing
  int           gap_max    = 0;
  int           burst_left = 0;

  // receiver pacing
  rx_style_e    rx_style     = RX_ALWAYS;
  int           rx_hold_req  = 0;
  int           rx_hold_left = 0;
  int unsigned  rx_phase     = 0;

  fnv1a64_record_hash_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // xor then multiply, one byte at a time, LSB first
  function automatic logic [63:0] fnv_bytes(input logic [63:0] h, input logic [63:0] v,
                                            input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      h = (h ^ {56'd0, v[7:0]}) * FNV_PRIME;
      v = v >> 8;
    end
    return h;
  endfunction

  function automatic logic [63:0] advance_digest(input opcode_e op, input hash_item_t it);
    logic [63:0] h;
    if (op == OP_BEGIN) begin
      h = fnv_bytes(FNV_BASIS, {32'd0, it.num_pools}, 4);
    end else begin
      h = fnv_bytes(digest_state, {32'd0, it.pool_id}, 4);
      h = fnv_bytes(h, {32'd0, it.grp_kind}, 4);
      h = fnv_bytes(h, {32'd0, it.rgn_code}, 4);
      h = fnv_bytes(h, it.block_size_bytes, 8);
      h = fnv_bytes(h, {32'd0, it.num_layers}, 4);
      h = fnv_bytes(h, {32'd0, it.alignment_bytes}, 4);
    end
    digest_state = h;
    return h;
  endfunction

  // ---------------------------------------------------------------------------
  // Random field values, biased toward the corners
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      3:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic hash_item_t rand_item();
    hash_item_t it;
    it.num_pools        = rand_word();
    it.pool_id          = rand_word();
    it.grp_kind         = rand_word();
    it.rgn_code         = rand_word();
    it.block_size_bytes = {rand_word(), rand_word()};
    it.num_layers       = rand_word();
    it.alignment_bytes  = rand_word();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drive one item, wait for the transaction, then maybe idle before the next.
  task automatic send_item(input opcode_e op, input hash_item_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    digest_q = {digest_q, advance_digest(op, it)};
    items_sent++;
    if (gap_max == 0 || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      gap = $urandom_range(1, gap_max);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= rand_item();   // junk while idle
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic send_begin(input logic [31:0] count);
    hash_item_t it;
    it           = rand_item();
    it.num_pools = count;
    send_item(OP_BEGIN, it);
  endtask

  // Stop offering and wait until every expected digest has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (digest_q.size() != 0);
  endtask

  task automatic set_pace(input rx_style_e style, input int gaps);
    rx_style   = style;
    gap_max    = gaps;
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern plus an on-demand long hold
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    rx_phase++;
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_axis_tready <= ((rx_phase % 11) >= 4);
        default:    m_axis_tready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [63:0] exp,
                               input logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("%0t: %s running_digest expected %h got %h", $realtime, what, exp, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        note_mismatch("unexpected transaction,", 'x, m_axis_tdata);
      end else begin
        want_digest = digest_q.pop_front();
        if (m_axis_tdata !== want_digest)
          note_mismatch("wrong", want_digest, m_axis_tdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Records before any begin mix into the offset basis left by reset.
  task automatic test_reset_basis();
    send_item(OP_RECORD, '0);
    send_item(OP_RECORD, rand_item());
  endtask

  task automatic test_field_extremes();
    hash_item_t it;
    send_begin('0);
    send_begin('1);
    send_begin(32'h0102_0304);     // byte order of the count
    send_item(OP_RECORD, '0);
    send_item(OP_RECORD, '1);
    send_item(OP_RECORD, {8{32'h5555_5555}});
    send_item(OP_RECORD, {8{32'haaaa_aaaa}});
    it                  = '0;     // distinct bytes expose field and byte order
    it.pool_id          = 32'h0403_0201;
    it.grp_kind         = 32'h0807_0605;
    it.rgn_code         = 32'h0c0b_0a09;
    it.block_size_bytes = 64'h1413_1211_100f_0e0d;
    it.num_layers       = 32'h1817_1615;
    it.alignment_bytes  = 32'h1c1b_1a19;
    send_item(OP_RECORD, it);
  endtask

  // A begin ignores the record fields, a record ignores the count.
  task automatic test_unused_fields();
    hash_item_t it;
    it           = '1;
    it.num_pools = 32'd7;
    send_item(OP_BEGIN, it);
    it           = rand_item();
    it.num_pools = '1;
    send_item(OP_RECORD, it);
  endtask

  // The record count is never enforced; lists may be short, long or empty.
  task automatic test_count_mismatch();
    send_begin(32'd3);
    send_item(OP_RECORD, rand_item());
    send_begin(32'd0);
    send_item(OP_RECORD, rand_item());
    send_item(OP_RECORD, rand_item());
    send_begin(32'd1);
    send_begin(32'd2);
  endtask

  // Receiver holds off while the sender keeps offering: the block must stall
  // its input and lose nothing. Then a full pause until everything is back.
  task automatic test_backpressure();
    drain_results();
    set_pace(RX_ALWAYS, 0);
    rx_hold_req = LONG_HOLD;
    @(posedge clk_i);
    for (int i = 0; i < 16; i++)
      send_item(i % 5 == 0 ? OP_BEGIN : OP_RECORD, rand_item());
    drain_results();
  endtask

  // Mostly well-formed lists with random content, some broken lists and noise.
  task automatic test_random_lists();
    int list_no;
    int n_rec;
    int kind;
    list_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case ((list_no / 25) % 4)
        0:       set_pace(RX_ALWAYS, 0);      // no idling at all
        1:       set_pace(RX_RANDOM, 40);
        2:       set_pace(RX_PATTERN, 6);
        default: set_pace(RX_RANDOM, 3);
      endcase
      kind  = $urandom_range(0, 9);
      n_rec = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      case (kind)
        0: begin                        // noise
          for (int i = 0; i < n_rec + 1; i++)
            send_item(opcode_e'($urandom_range(0, 1)), rand_item());
        end
        1: begin                        // count disagrees with the records sent
          send_begin($urandom_range(0, 1) ? rand_word()
                                          : 32'(n_rec + $urandom_range(1, 3)));
          for (int i = 0; i < n_rec; i++)
            send_item(OP_RECORD, rand_item());
        end
        default: begin                  // well-formed list
          send_begin(32'(n_rec));
          for (int i = 0; i < n_rec; i++)
            send_item(OP_RECORD, rand_item());
        end
      endcase
      list_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pace(RX_RANDOM, 6);
    test_reset_basis();
    test_field_extremes();
    test_unused_fields();
    test_count_mismatch();
    test_backpressure();
    test_random_lists();

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0 && digest_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(30_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
